// File: hw/rtl/time_paced_frame_ring_buffer_assert.svh
// assertion macros used by the paced ring buffer top level
`ifndef TIME_PACED_FRAME_RING_BUFFER_ASSERT_SVH
`define TIME_PACED_FRAME_RING_BUFFER_ASSERT_SVH

// same-cycle implication, off during reset
`define TPFRB_ASSERT_HOLDS(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define TPFRB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tpfrb_pkg.sv
// constants, codes and types of the paced ring buffer
`timescale 1ns / 1ps

package tpfrb_pkg;

	localparam int RING_DEPTH = 256;
	localparam int LANE_COUNT = 4;
	localparam int IN_LANES   = 4;
	localparam int RATE_W     = 16;
	localparam int ENTRY_W    = LANE_COUNT * RATE_W;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int EFF_W      = $clog2(RING_DEPTH + 1);
	localparam int DEPTH_W    = 9;
	localparam int EXT_W      = (EFF_W > DEPTH_W) ? EFF_W : DEPTH_W;
	localparam int FPI_W      = 16;
	localparam int SUM_W      = FPI_W + 1;
	localparam int DVD_W      = SUM_W + 1;
	localparam int DVS_W      = 16;
	localparam int CNT_W      = $clog2(DVD_W);
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_W      = 16;
	localparam int IN_DATA_W  = IN_LANES * RATE_W + FPI_W;
	localparam int OUT_DATA_W = IN_LANES * RATE_W;
	localparam int ELAPSED_LSB = IN_LANES * RATE_W;

	localparam logic [FPI_W-1:0]   FPI_RESET   = FPI_W'(256);
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(256);

	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USED_DEPTH       = 1'd1;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: hw/rtl/tpfrb_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module tpfrb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/tpfrb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tpfrb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tpfrb_pkg::div_req_t req,
	output tpfrb_pkg::div_rsp_t rsp
);

	import tpfrb_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nxt;

	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = !diff[DVS_W];
		rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hw/rtl/time_paced_frame_ring_buffer.sv
// paced ring buffer of four-lane rate entries, top level
`timescale 1ns / 1ps

// Ring of 256 entries of four 16-bit lanes, written by enqueue items and read back at a
// paced rate by dequeue items; clear resets both pointers. One item is worked at a time
// and every item gives exactly one result item on m_*; found (m_tuser) is 0 with all lanes
// zero when nothing is returned. A dequeue runs the bit-serial divider for frame pacing
// and ends there when the step count is zero or the ring is empty, reads the entry
// directly when it steps one entry, and takes a second divider pass for the ring wrap
// when it steps further. Each divider pass gives one quotient bit a cycle. The entry
// store has no reset; the result register lets the next item be taken while a result
// waits.

module time_paced_frame_ring_buffer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// rate_a, rate_b, rate_c, rate_d, elapsed_frames
	input  logic [tpfrb_pkg::IN_DATA_W-1:0]       s_tdata,
	// operation
	input  logic [tpfrb_pkg::OP_W-1:0]            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_rate_a, out_rate_b, out_rate_c, out_rate_d
	output logic [tpfrb_pkg::OUT_DATA_W-1:0]      m_tdata,
	// found
	output logic                                  m_tuser,
	input  logic                                  cfg_we,
	input  logic [tpfrb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpfrb_pkg::CFG_W-1:0]           cfg_data
);

	`include "time_paced_frame_ring_buffer_assert.svh"

	import tpfrb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;
	localparam logic [2:0] ST_PLAN = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]            state_q;
	logic [FPI_W-1:0]      fpi_q;
	logic [DEPTH_W-1:0]    used_depth_q;
	logic [PTR_W-1:0]      rp_q;
	logic [PTR_W-1:0]      wp_q;
	logic [FPI_W-1:0]      frem_q;
	logic [SUM_W-1:0]      step_q;
	logic [EFF_W-1:0]      dist_q;
	logic                  reach_q;
	logic                  found_q;
	logic [PTR_W-1:0]      last_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic [EXT_W-1:0]      ud_ext;
	logic [EFF_W-1:0]      eff;
	logic                  rp_in;
	logic                  wp_in;
	logic [EFF_W-1:0]      dist_w;
	logic                  reach_w;
	logic [SUM_W-1:0]      dist_ext;
	logic [SUM_W-1:0]      m_w;
	logic [DVD_W-1:0]      x_w;
	logic [SUM_W-1:0]      sum_w;
	logic                  s_accept;
	logic                  out_free;
	logic                  ram_we;
	logic                  ram_re;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [OUT_DATA_W-1:0] lanes_out;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
	                                         input logic [EFF_W-1:0] e);
		logic [EFF_W-1:0] nx;
		nx = EFF_W'(p) + EFF_W'(1);
		return (nx >= e) ? '0 : nx[PTR_W-1:0];
	endfunction

	// effective ring depth
	always_comb begin
		ud_ext = EXT_W'(used_depth_q);
		if (used_depth_q == '0) begin
			eff = EFF_W'(1);
		end else if (ud_ext > EXT_W'(RING_DEPTH)) begin
			eff = EFF_W'(RING_DEPTH);
		end else begin
			eff = EFF_W'(ud_ext);
		end
	end

	// distance from read to write pointer along the advance sequence
	always_comb begin
		rp_in   = EFF_W'(rp_q) < eff;
		wp_in   = EFF_W'(wp_q) < eff;
		reach_w = 1'b0;
		dist_w  = '0;
		if (rp_in && wp_in) begin
			reach_w = 1'b1;
			dist_w  = (wp_q > rp_q) ? EFF_W'(wp_q) - EFF_W'(rp_q)
			                        : EFF_W'(wp_q) - EFF_W'(rp_q) + eff;
		end else if (wp_in) begin
			reach_w = 1'b1;
			dist_w  = EFF_W'(wp_q) + EFF_W'(1);
		end
	end

	// moves taken and the value to wrap for the last entry passed
	always_comb begin
		dist_ext = SUM_W'(dist_q);
		m_w      = (reach_q && dist_ext < step_q) ? dist_ext : step_q;
		x_w      = rp_in ? DVD_W'(rp_q) + DVD_W'(m_w) - DVD_W'(1)
		                 : DVD_W'(m_w) - DVD_W'(2);
		sum_w    = SUM_W'(frem_q) + SUM_W'(s_tdata[ELAPSED_LSB +: FPI_W]);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		div_req = '0;
		if (s_accept && s_tuser == OP_DEQUEUE) begin
			div_req.start    = 1'b1;
			div_req.dividend = DVD_W'(sum_w);
			div_req.divisor  = (fpi_q == '0) ? DVS_W'(1) : DVS_W'(fpi_q);
		end else if (state_q == ST_STEP && m_w != SUM_W'(1)) begin
			div_req.start    = 1'b1;
			div_req.dividend = x_w;
			div_req.divisor  = DVS_W'(eff);
		end
	end

	assign ram_we = s_accept && s_tuser == OP_ENQUEUE;
	assign ram_re = (state_q == ST_READ);

	for (genvar k = 0; k < LANE_COUNT; k++) begin : g_wlane
		if (k < IN_LANES) begin : g_in
			assign ram_wdata[k*RATE_W +: RATE_W] = s_tdata[k*RATE_W +: RATE_W];
		end else begin : g_zero
			assign ram_wdata[k*RATE_W +: RATE_W] = '0;
		end
	end

	for (genvar k = 0; k < IN_LANES; k++) begin : g_rlane
		if (k < LANE_COUNT) begin : g_in
			assign lanes_out[k*RATE_W +: RATE_W] = ram_rdata[k*RATE_W +: RATE_W];
		end else begin : g_zero
			assign lanes_out[k*RATE_W +: RATE_W] = '0;
		end
	end

	tpfrb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (last_q),
		.rdata (ram_rdata)
	);

	tpfrb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpi_q        <= FPI_RESET;
			used_depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAMES_PER_INDEX: fpi_q <= cfg_data[FPI_W-1:0];
				REG_USED_DEPTH:       used_depth_q <= cfg_data[DEPTH_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rp_q       <= '0;
			wp_q       <= '0;
			frem_q     <= '0;
			step_q     <= '0;
			dist_q     <= '0;
			reach_q    <= 1'b0;
			found_q    <= 1'b0;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					found_q <= 1'b0;
					if (s_accept) begin
						unique case (s_tuser)
							OP_ENQUEUE: begin
								wp_q    <= adv(wp_q, eff);
								state_q <= ST_FIN;
							end
							OP_DEQUEUE: begin
								state_q <= ST_DIV1;
							end
							OP_CLEAR: begin
								rp_q    <= '0;
								wp_q    <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						frem_q  <= div_rsp.remainder[FPI_W-1:0];
						step_q  <= div_rsp.quotient[SUM_W-1:0];
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					dist_q  <= dist_w;
					reach_q <= reach_w;
					if (step_q == '0 || rp_q == wp_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (m_w == SUM_W'(1)) begin
						last_q  <= rp_q;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						last_q  <= div_rsp.remainder[PTR_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rp_q    <= adv(last_q, eff);
					found_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tuser_q <= found_q;
			m_tdata_q <= found_q ? lanes_out : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`TPFRB_ASSERT_HOLDS(a_nofound_zero, m_tvalid && !m_tuser, m_tdata == '0, "lanes set without found")
	`TPFRB_ASSERT_HOLDS(a_div_done_wait, div_rsp.done, state_q == ST_DIV1 || state_q == ST_DIV2, "divider done outside a wait state")
	`TPFRB_ASSERT_NEXT(a_rp_hold, state_q != ST_READ && !(s_accept && s_tuser == OP_CLEAR), $stable(rp_q), "read pointer moved outside read or clear")

endmodule

// File: test/tb_top.sv
// testbench for the paced ring buffer: queued stream items, predicted results, checked in order
`timescale 1ns / 1ps

module tb_top;
	import tpfrb_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 80;

	typedef struct packed {
		logic [OP_W-1:0]                  op;
		logic [FPI_W-1:0]                 elapsed;
		logic [IN_LANES-1:0][RATE_W-1:0]  rate;
	} ring_item_t;

	typedef struct packed {
		logic                             found;
		logic [IN_LANES-1:0][RATE_W-1:0]  lane;
	} ring_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_W-1:0]     s_tdata = '0;
	logic [OP_W-1:0]          s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]    m_tdata;
	logic                     m_tuser;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;

	time_paced_frame_ring_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor copy of the block state
	logic [IN_LANES-1:0][RATE_W-1:0] ring_lanes [RING_DEPTH];
	int                              rd_ptr = 0;
	int                              wr_ptr = 0;
	int                              frame_rem = 0;
	logic [FPI_W-1:0]                cfg_fpi = FPI_RESET;
	logic [DEPTH_W-1:0]              cfg_depth = DEPTH_RESET;

	ring_item_t   pending_items [$];
	ring_result_t expected_results [$];
	ring_item_t   drv_item;

	int items_queued = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int found_count = 0;
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int phase_count = 0;

	function automatic int ring_advance(int p);
		int depth;
		depth = (cfg_depth == 0) ? 1 : ((int'(cfg_depth) > RING_DEPTH) ? RING_DEPTH : int'(cfg_depth));
		p++;
		if (p >= depth) p = 0;
		return p;
	endfunction

	function automatic ring_result_t pace_ring_step(ring_item_t it);
		ring_result_t r;
		int div;
		int sum;
		int steps;
		int last;
		int i;
		bit moved;
		r = '0;
		moved = 1'b0;
		case (it.op)
			OP_ENQUEUE: begin
				ring_lanes[wr_ptr % RING_DEPTH] = it.rate;
				wr_ptr = ring_advance(wr_ptr);
			end
			OP_DEQUEUE: begin
				div = (cfg_fpi == 0) ? 1 : int'(cfg_fpi);
				sum = frame_rem + int'(it.elapsed);
				steps = sum / div;
				frame_rem = sum % div;
				last = rd_ptr;
				for (i = 0; i < steps && rd_ptr != wr_ptr; i++) begin
					last = rd_ptr;
					rd_ptr = ring_advance(rd_ptr);
					moved = 1'b1;
				end
				if (moved) begin
					r.found = 1'b1;
					r.lane = ring_lanes[last % RING_DEPTH];
				end
			end
			OP_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic ring_item_t mk(logic [OP_W-1:0] op, logic [63:0] rates,
			logic [FPI_W-1:0] elapsed);
		ring_item_t it;
		it.op = op;
		it.rate = rates;
		it.elapsed = elapsed;
		return it;
	endfunction

	function automatic logic [FPI_W-1:0] pick_elapsed(logic [FPI_W-1:0] fpi);
		int unit;
		int v;
		unit = (fpi == 0) ? 1 : int'(fpi);
		case ($urandom_range(3))
			0: v = $urandom_range(65535);
			// fraction of one entry only, builds up the remainder
			1: v = $urandom_range(unit - 1);
			default: v = unit * $urandom_range(3) + $urandom_range(unit / 4);
		endcase
		if (v > 65535) v = $urandom_range(65535);
		return FPI_W'(v);
	endfunction

	task automatic queue_item(ring_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random(int n, logic [FPI_W-1:0] fpi);
		int left;
		int burst;
		int roll;
		left = n;
		while (left > 0) begin
			roll = $urandom_range(99);
			burst = $urandom_range(8, 1);
			if (burst > left) burst = left;
			if (roll < 45) begin
				repeat (burst) queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, FPI_W'($urandom)));
			end else if (roll < 90) begin
				repeat (burst) queue_item(mk(OP_DEQUEUE, {$urandom, $urandom}, pick_elapsed(fpi)));
			end else if (roll < 95) begin
				queue_item(mk(OP_CLEAR, {$urandom, $urandom}, FPI_W'($urandom)));
				burst = 1;
			end else begin
				queue_item(mk(OP_RESERVED, {$urandom, $urandom}, FPI_W'($urandom)));
				burst = 1;
			end
			left -= burst;
		end
	endtask

	task automatic wait_drained();
		while (!(items_accepted == items_queued && expected_results.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_FRAMES_PER_INDEX) cfg_fpi = value[FPI_W-1:0];
		else cfg_depth = value[DEPTH_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [FPI_W-1:0] fpi, logic [DEPTH_W-1:0] depth,
			int send_pct, int recv_pct, bit hold);
		wait_drained();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_reg(REG_FRAMES_PER_INDEX, CFG_W'(fpi));
		write_reg(REG_USED_DEPTH, CFG_W'(depth));
		queue_random(PHASE_ITEMS / 2, fpi);
		if (hold) hold_requests++;
		// sender pauses until every result of the first half is back
		wait_drained();
		queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, fpi);
		phase_count++;
	endtask

	task automatic check_field(string name, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(pace_ring_step(drv_item));
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {drv_item.elapsed, drv_item.rate};
					s_tuser <= drv_item.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ring_result_t got;
		ring_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.lane = m_tdata;
				results_seen++;
				if (got.found) found_count++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item, expected none, actual found=%0b lanes=%h",
						$time, got.found, got.lane);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("found", RATE_W'(want.found), RATE_W'(got.found));
					check_field("out_rate_a", want.lane[0], got.lane[0]);
					check_field("out_rate_b", want.lane[1], got.lane[1]);
					check_field("out_rate_c", want.lane[2], got.lane[2]);
					check_field("out_rate_d", want.lane[3], got.lane[3]);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, expected_results.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 34;
		recv_idle_pct = 80;

		// directed items at reset settings
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0000));
		queue_item(mk(OP_DEQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0200));
		queue_item(mk(OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
		queue_item(mk(OP_ENQUEUE, 64'h0, 16'h0000));
		queue_item(mk(OP_ENQUEUE, 64'hAAAA_5555_8000_0001, 16'h1234));
		queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, 16'h0000));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h00FF));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0001));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'hFFFF));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'hFFFF));
		queue_item(mk(OP_RESERVED, {$urandom, $urandom}, FPI_W'($urandom)));
		queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, 16'h0000));
		queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, 16'h0000));
		queue_item(mk(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0100));
		for (i = 0; i < 3; i++)
			queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, 16'hFFFF));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0300));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0180));
		queue_item(mk(OP_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
		queue_item(mk(OP_DEQUEUE, 64'h0, 16'h0100));

		// write every entry once so later depth changes never read stale slots
		for (i = 0; i < RING_DEPTH; i++)
			queue_item(mk(OP_ENQUEUE, {$urandom, $urandom}, FPI_W'($urandom)));
		phase_count++;

		run_phase(16'd1,     9'd256, 34, 80, 1'b1);
		run_phase(16'd65535, 9'd1,   34, 80, 1'b0);
		run_phase(16'd0,     9'd0,   34, 80, 1'b0);
		run_phase(16'd384,   9'd511, 80, 34, 1'b0);
		run_phase(16'd128,   9'd5,   80, 34, 1'b0);
		run_phase(FPI_W'($urandom_range(65535, 1)), DEPTH_W'($urandom_range(256, 1)),
			80, 34, 1'b1);
		run_phase(FPI_W'($urandom_range(1023, 1)), DEPTH_W'($urandom_range(256, 1)),
			0, 0, 1'b0);
		run_phase(16'd96,    9'd200, 0, 0, 1'b0);
		run_phase(16'd256,   9'd256, 0, 0, 1'b0);

		wait_drained();
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			error_count++;
		end
		$display("covered %0d items over %0d settings, %0d results checked, %0d carried an entry",
			items_accepted, phase_count, results_seen, found_count);
		$display("mismatches seen: %0d", error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
